// ===== rtl/core/wras_pkg.sv =====
package wras_pkg;

    localparam int VAL_W  = 30;
    localparam int KIND_W = 2;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 11;

    localparam logic [VAL_W-1:0] MODULUS_RESET = 30'd1008610010;
    localparam logic [CNT_W-1:0] ECOUNT_RESET  = 11'd1;
    localparam logic [VAL_W-1:0] MODULUS_MIN   = 30'd2;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic CFG_ECOUNT  = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    typedef logic [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t sum;
        val_t weight;
        val_t pending;
    } node_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  range_left;
        logic [POS_W-1:0]  range_right;
        val_t              operand_value;
    } item_t;

    typedef struct packed {
        logic status;
        val_t range_sum;
    } result_t;

    typedef enum logic [1:0] {
        ALU_RED,
        ALU_ADD,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        val_t    a;
        val_t    b;
    } alu_req_t;

    typedef struct packed {
        logic done;
        val_t result;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_RA,
        AL_RB,
        AL_SUM,
        AL_MUL,
        AL_RP
    } alu_state_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_AWAIT,
        S_MWAIT,
        S_VISIT,
        S_VIS_CHK,
        S_QACC,
        S_PD0,
        S_PD2,
        S_PD3,
        S_AP0,
        S_AP1,
        S_AP2,
        S_AP3,
        S_DESC,
        S_RETURN,
        S_AFTL,
        S_AFTR,
        S_SUM0,
        S_SUM1,
        S_SUM2,
        S_SUM3,
        S_LD_VISIT,
        S_LD_CHK,
        S_LD_W,
        S_LD_DESC,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic clearing;
        logic take;
        logic res_valid;
    } ctrl_stat_t;

endpackage

// ===== rtl/core/wras_node_mem.sv =====
module wras_node_mem #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  wras_pkg::node_t     wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output wras_pkg::node_t     rdata
);

    wras_pkg::node_t mem [DEPTH];
    wras_pkg::node_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wras_alu.sv =====
module wras_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  wras_pkg::alu_req_t req,
    input  wras_pkg::val_t     modulus,
    output wras_pkg::alu_rsp_t rsp
);

    wras_pkg::alu_state_t st_reg, st_next;
    wras_pkg::alu_op_t    op_reg, op_next;
    wras_pkg::val_t       b_reg, b_next;
    wras_pkg::val_t       ra_reg, ra_next;
    wras_pkg::val_t       rem_reg, rem_next;
    wras_pkg::val_t       res_reg, res_next;
    logic [59:0]          sh_reg, sh_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [30:0]          r2;
    logic [30:0]          mod_ext;
    logic [30:0]          rsub;
    wras_pkg::val_t       rnew;
    logic                 last;
    logic [30:0]          s_sum;
    logic [30:0]          s_sub;

    // one remainder bit per cycle: r = 2r + next bit, subtract modulus if it fits
    always_comb begin
        mod_ext = {1'b0, modulus};
        r2      = {rem_reg, sh_reg[59]};
        rsub    = r2 - mod_ext;
        rnew    = (r2 >= mod_ext) ? rsub[29:0] : r2[29:0];
        last    = (cnt_reg == 6'd1);
        s_sum   = {1'b0, ra_reg} + {1'b0, b_reg};
        s_sub   = s_sum - mod_ext;
    end

    always_comb begin
        st_next   = st_reg;
        op_next   = op_reg;
        b_next    = b_reg;
        ra_next   = ra_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (st_reg)
            wras_pkg::AL_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    b_next   = req.b;
                    sh_next  = {req.a, 30'd0};
                    rem_next = '0;
                    cnt_next = 6'd30;
                    st_next  = wras_pkg::AL_RA;
                end
            end
            wras_pkg::AL_RA: begin
                rem_next = rnew;
                sh_next  = {sh_reg[58:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last) begin
                    ra_next = rnew;
                    if (op_reg == wras_pkg::ALU_RED) begin
                        res_next  = rnew;
                        done_next = 1'b1;
                        st_next   = wras_pkg::AL_IDLE;
                    end else begin
                        sh_next  = {b_reg, 30'd0};
                        rem_next = '0;
                        cnt_next = 6'd30;
                        st_next  = wras_pkg::AL_RB;
                    end
                end
            end
            wras_pkg::AL_RB: begin
                rem_next = rnew;
                sh_next  = {sh_reg[58:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last) begin
                    b_next  = rnew;
                    st_next = (op_reg == wras_pkg::ALU_ADD) ? wras_pkg::AL_SUM
                                                            : wras_pkg::AL_MUL;
                end
            end
            wras_pkg::AL_SUM: begin
                res_next  = (s_sum >= mod_ext) ? s_sub[29:0] : s_sum[29:0];
                done_next = 1'b1;
                st_next   = wras_pkg::AL_IDLE;
            end
            wras_pkg::AL_MUL: begin
                sh_next  = ra_reg * b_reg;
                rem_next = '0;
                cnt_next = 6'd60;
                st_next  = wras_pkg::AL_RP;
            end
            wras_pkg::AL_RP: begin
                rem_next = rnew;
                sh_next  = {sh_reg[58:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last) begin
                    res_next  = rnew;
                    done_next = 1'b1;
                    st_next   = wras_pkg::AL_IDLE;
                end
            end
            default: begin
                st_next = wras_pkg::AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= wras_pkg::AL_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        b_reg   <= b_next;
        ra_reg  <= ra_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== rtl/core/wras_ctrl.sv =====
module wras_ctrl #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int NW           = 12,
    parameter int PW           = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  wras_pkg::item_t                     in_item,
    input  logic                                out_free,
    input  logic [wras_pkg::CNT_W-1:0]          ecount,
    output wras_pkg::ctrl_stat_t                stat,
    output wras_pkg::result_t                   result,
    output wras_pkg::alu_req_t                  alu_req,
    input  wras_pkg::alu_rsp_t                  alu_rsp,
    output logic                                mem_we,
    output logic [NW-1:0]                       mem_waddr,
    output wras_pkg::node_t                     mem_wdata,
    output logic                                mem_re,
    output logic [NW-1:0]                       mem_raddr,
    input  wras_pkg::node_t                     mem_rdata
);

    localparam int CW         = (PW > wras_pkg::POS_W) ? PW : wras_pkg::POS_W;
    localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
    localparam int SD         = $clog2(MAX_ELEMENTS) + 1;
    localparam int SIW        = $clog2(SD);
    localparam int SPW        = $clog2(SD + 1);

    wras_pkg::ctrl_state_t state_reg, state_next;
    wras_pkg::ctrl_state_t alu_ret_reg, alu_ret_next;
    wras_pkg::ctrl_state_t mem_ret_reg, mem_ret_next;
    wras_pkg::ctrl_state_t pd_ret_reg, pd_ret_next;
    wras_pkg::ctrl_state_t ap_ret_reg, ap_ret_next;

    logic [wras_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [wras_pkg::POS_W-1:0]  l_reg, l_next;
    logic [wras_pkg::POS_W-1:0]  r_reg, r_next;
    wras_pkg::val_t              v_reg, v_next;
    wras_pkg::val_t              acc_reg, acc_next;
    wras_pkg::val_t              tmp_reg, tmp_next;
    wras_pkg::val_t              apv_reg, apv_next;
    logic                        status_reg, status_next;
    logic [NW-1:0]               cur_k_reg, cur_k_next;
    logic [PW-1:0]               cur_lo_reg, cur_lo_next;
    logic [PW-1:0]               cur_hi_reg, cur_hi_next;
    logic [NW-1:0]               ap_addr_reg, ap_addr_next;
    logic [NW-1:0]               clr_addr_reg, clr_addr_next;
    logic [SPW-1:0]              sp_reg, sp_next;
    wras_pkg::node_t             node_reg, node_next;

    // call stack of partly visited nodes; phase set means the left child is done
    logic [NW-1:0]               stk_k  [SD];
    logic [PW-1:0]               stk_lo [SD];
    logic [PW-1:0]               stk_hi [SD];
    logic                        stk_ph [SD];
    logic                        push_en;
    logic                        push_ph;
    logic [SPW-1:0]              sp_dec;
    logic [SIW-1:0]              push_idx;
    logic [SIW-1:0]              pop_idx;

    logic [PW:0]                 mid_sum;
    logic [PW-1:0]               mid;
    logic [PW-1:0]               mid_inc;
    logic [CW-1:0]               l_ext, r_ext, lo_ext, hi_ext, mid_ext;
    logic                        covered, go_left, go_right, leaf;
    logic [NW-1:0]               kid_l, kid_r;
    logic [CW-1:0]               in_l_ext, in_r_ext, ec_ext;
    logic                        item_bad;

    always_comb begin
        mid_sum  = {1'b0, cur_lo_reg} + {1'b0, cur_hi_reg};
        mid      = mid_sum[PW:1];
        mid_inc  = mid + PW'(1);
        l_ext    = CW'(l_reg);
        r_ext    = CW'(r_reg);
        lo_ext   = CW'(cur_lo_reg);
        hi_ext   = CW'(cur_hi_reg);
        mid_ext  = CW'(mid);
        covered  = (l_ext <= lo_ext) && (hi_ext <= r_ext);
        go_left  = (l_ext <= mid_ext);
        go_right = (r_ext > mid_ext);
        leaf     = (cur_lo_reg == cur_hi_reg);
        kid_l    = {cur_k_reg[NW-2:0], 1'b0};
        kid_r    = {cur_k_reg[NW-2:0], 1'b1};
        sp_dec   = sp_reg - SPW'(1);
        push_idx = sp_reg[SIW-1:0];
        pop_idx  = sp_dec[SIW-1:0];
        in_l_ext = CW'(in_item.range_left);
        in_r_ext = CW'(in_item.range_right);
        ec_ext   = CW'(ecount);
        case (in_item.kind)
            wras_pkg::KIND_LOAD: begin
                item_bad = (in_l_ext == '0) || (in_l_ext > ec_ext);
            end
            wras_pkg::KIND_ADD, wras_pkg::KIND_QUERY: begin
                item_bad = (in_l_ext == '0) || (in_r_ext > ec_ext) || (in_l_ext > in_r_ext);
            end
            default: begin
                item_bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        alu_ret_next  = alu_ret_reg;
        mem_ret_next  = mem_ret_reg;
        pd_ret_next   = pd_ret_reg;
        ap_ret_next   = ap_ret_reg;
        kind_next     = kind_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        v_next        = v_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        apv_next      = apv_reg;
        status_next   = status_reg;
        cur_k_next    = cur_k_reg;
        cur_lo_next   = cur_lo_reg;
        cur_hi_next   = cur_hi_reg;
        ap_addr_next  = ap_addr_reg;
        clr_addr_next = clr_addr_reg;
        sp_next       = sp_reg;
        node_next     = node_reg;
        push_en       = 1'b0;
        push_ph       = 1'b0;
        alu_req       = '{start: 1'b0, op: wras_pkg::ALU_RED, a: '0, b: '0};
        mem_we        = 1'b0;
        mem_waddr     = cur_k_reg;
        mem_wdata     = node_reg;
        mem_re        = 1'b0;
        mem_raddr     = cur_k_reg;
        stat          = '{clearing: 1'b0, take: 1'b0, res_valid: 1'b0};

        case (state_reg)
            wras_pkg::S_CLEAR: begin
                stat.clearing = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + NW'(1);
                if (clr_addr_reg == NW'(NODE_DEPTH - 1)) begin
                    state_next = wras_pkg::S_IDLE;
                end
            end
            wras_pkg::S_IDLE: begin
                if (in_valid) begin
                    stat.take   = 1'b1;
                    kind_next   = in_item.kind;
                    l_next      = in_item.range_left;
                    r_next      = in_item.range_right;
                    acc_next    = '0;
                    status_next = item_bad;
                    if (item_bad) begin
                        state_next = wras_pkg::S_FIN;
                    end else begin
                        alu_req      = '{start: 1'b1, op: wras_pkg::ALU_RED,
                                         a: in_item.operand_value, b: '0};
                        alu_ret_next = wras_pkg::S_START;
                        state_next   = wras_pkg::S_AWAIT;
                    end
                end
            end
            wras_pkg::S_START: begin
                v_next      = alu_rsp.result;
                cur_k_next  = NW'(1);
                cur_lo_next = PW'(1);
                cur_hi_next = PW'(MAX_ELEMENTS);
                sp_next     = '0;
                state_next  = (kind_reg == wras_pkg::KIND_LOAD) ? wras_pkg::S_LD_VISIT
                                                                : wras_pkg::S_VISIT;
            end
            wras_pkg::S_AWAIT: begin
                if (alu_rsp.done) begin
                    state_next = alu_ret_reg;
                end
            end
            wras_pkg::S_MWAIT: begin
                node_next  = mem_rdata;
                state_next = mem_ret_reg;
            end
            wras_pkg::S_VISIT: begin
                mem_re       = 1'b1;
                mem_raddr    = cur_k_reg;
                mem_ret_next = wras_pkg::S_VIS_CHK;
                state_next   = wras_pkg::S_MWAIT;
            end
            wras_pkg::S_VIS_CHK: begin
                if (covered) begin
                    if (kind_reg == wras_pkg::KIND_ADD) begin
                        ap_addr_next = cur_k_reg;
                        apv_next     = v_reg;
                        ap_ret_next  = wras_pkg::S_RETURN;
                        state_next   = wras_pkg::S_AP0;
                    end else begin
                        alu_req      = '{start: 1'b1, op: wras_pkg::ALU_ADD,
                                         a: acc_reg, b: node_reg.sum};
                        alu_ret_next = wras_pkg::S_QACC;
                        state_next   = wras_pkg::S_AWAIT;
                    end
                end else begin
                    alu_req      = '{start: 1'b1, op: wras_pkg::ALU_RED,
                                     a: node_reg.pending, b: '0};
                    alu_ret_next = wras_pkg::S_PD0;
                    pd_ret_next  = wras_pkg::S_DESC;
                    state_next   = wras_pkg::S_AWAIT;
                end
            end
            wras_pkg::S_QACC: begin
                acc_next   = alu_rsp.result;
                state_next = wras_pkg::S_RETURN;
            end
            // push-down: clear the parent's pending, then apply it to both children
            wras_pkg::S_PD0: begin
                mem_we    = 1'b1;
                mem_waddr = cur_k_reg;
                mem_wdata = '{sum: node_reg.sum, weight: node_reg.weight, pending: '0};
                if (alu_rsp.result != '0) begin
                    apv_next     = alu_rsp.result;
                    ap_addr_next = kid_l;
                    ap_ret_next  = wras_pkg::S_PD2;
                    mem_re       = 1'b1;
                    mem_raddr    = kid_l;
                    mem_ret_next = wras_pkg::S_AP0;
                    state_next   = wras_pkg::S_MWAIT;
                end else begin
                    state_next = pd_ret_reg;
                end
            end
            wras_pkg::S_PD2: begin
                ap_addr_next = kid_r;
                ap_ret_next  = wras_pkg::S_PD3;
                mem_re       = 1'b1;
                mem_raddr    = kid_r;
                mem_ret_next = wras_pkg::S_AP0;
                state_next   = wras_pkg::S_MWAIT;
            end
            wras_pkg::S_PD3: begin
                state_next = pd_ret_reg;
            end
            wras_pkg::S_AP0: begin
                alu_req      = '{start: 1'b1, op: wras_pkg::ALU_ADD,
                                 a: node_reg.pending, b: apv_reg};
                alu_ret_next = wras_pkg::S_AP1;
                state_next   = wras_pkg::S_AWAIT;
            end
            wras_pkg::S_AP1: begin
                tmp_next     = alu_rsp.result;
                alu_req      = '{start: 1'b1, op: wras_pkg::ALU_MUL,
                                 a: node_reg.weight, b: apv_reg};
                alu_ret_next = wras_pkg::S_AP2;
                state_next   = wras_pkg::S_AWAIT;
            end
            wras_pkg::S_AP2: begin
                alu_req      = '{start: 1'b1, op: wras_pkg::ALU_ADD,
                                 a: node_reg.sum, b: alu_rsp.result};
                alu_ret_next = wras_pkg::S_AP3;
                state_next   = wras_pkg::S_AWAIT;
            end
            wras_pkg::S_AP3: begin
                mem_we     = 1'b1;
                mem_waddr  = ap_addr_reg;
                mem_wdata  = '{sum: alu_rsp.result, weight: node_reg.weight,
                               pending: tmp_reg};
                state_next = ap_ret_reg;
            end
            wras_pkg::S_DESC: begin
                if (go_left) begin
                    push_en     = 1'b1;
                    push_ph     = 1'b0;
                    sp_next     = sp_reg + SPW'(1);
                    cur_k_next  = kid_l;
                    cur_hi_next = mid;
                    state_next  = wras_pkg::S_VISIT;
                end else begin
                    state_next = wras_pkg::S_AFTL;
                end
            end
            wras_pkg::S_RETURN: begin
                if (sp_reg == '0) begin
                    state_next = wras_pkg::S_FIN;
                end else begin
                    cur_k_next  = stk_k[pop_idx];
                    cur_lo_next = stk_lo[pop_idx];
                    cur_hi_next = stk_hi[pop_idx];
                    sp_next     = sp_dec;
                    state_next  = stk_ph[pop_idx] ? wras_pkg::S_AFTR : wras_pkg::S_AFTL;
                end
            end
            wras_pkg::S_AFTL: begin
                if (go_right) begin
                    push_en     = 1'b1;
                    push_ph     = 1'b1;
                    sp_next     = sp_reg + SPW'(1);
                    cur_k_next  = kid_r;
                    cur_lo_next = mid_inc;
                    state_next  = wras_pkg::S_VISIT;
                end else begin
                    state_next = wras_pkg::S_AFTR;
                end
            end
            wras_pkg::S_AFTR: begin
                if (kind_reg == wras_pkg::KIND_QUERY) begin
                    state_next = wras_pkg::S_RETURN;
                end else begin
                    mem_re       = 1'b1;
                    mem_raddr    = kid_l;
                    mem_ret_next = wras_pkg::S_SUM0;
                    state_next   = wras_pkg::S_MWAIT;
                end
            end
            wras_pkg::S_SUM0: begin
                tmp_next     = node_reg.sum;
                mem_re       = 1'b1;
                mem_raddr    = kid_r;
                mem_ret_next = wras_pkg::S_SUM1;
                state_next   = wras_pkg::S_MWAIT;
            end
            wras_pkg::S_SUM1: begin
                alu_req      = '{start: 1'b1, op: wras_pkg::ALU_ADD,
                                 a: tmp_reg, b: node_reg.sum};
                alu_ret_next = wras_pkg::S_SUM2;
                state_next   = wras_pkg::S_AWAIT;
            end
            wras_pkg::S_SUM2: begin
                tmp_next     = alu_rsp.result;
                mem_re       = 1'b1;
                mem_raddr    = cur_k_reg;
                mem_ret_next = wras_pkg::S_SUM3;
                state_next   = wras_pkg::S_MWAIT;
            end
            wras_pkg::S_SUM3: begin
                mem_we     = 1'b1;
                mem_waddr  = cur_k_reg;
                mem_wdata  = '{sum: tmp_reg, weight: node_reg.weight,
                               pending: node_reg.pending};
                state_next = wras_pkg::S_RETURN;
            end
            wras_pkg::S_LD_VISIT: begin
                mem_re       = 1'b1;
                mem_raddr    = cur_k_reg;
                mem_ret_next = wras_pkg::S_LD_CHK;
                state_next   = wras_pkg::S_MWAIT;
            end
            wras_pkg::S_LD_CHK: begin
                alu_req      = '{start: 1'b1, op: wras_pkg::ALU_ADD,
                                 a: node_reg.weight, b: v_reg};
                alu_ret_next = wras_pkg::S_LD_W;
                state_next   = wras_pkg::S_AWAIT;
            end
            wras_pkg::S_LD_W: begin
                node_next.weight = alu_rsp.result;
                if (leaf) begin
                    mem_we     = 1'b1;
                    mem_waddr  = cur_k_reg;
                    mem_wdata  = '{sum: node_reg.sum, weight: alu_rsp.result,
                                   pending: node_reg.pending};
                    state_next = wras_pkg::S_FIN;
                end else begin
                    alu_req      = '{start: 1'b1, op: wras_pkg::ALU_RED,
                                     a: node_reg.pending, b: '0};
                    alu_ret_next = wras_pkg::S_PD0;
                    pd_ret_next  = wras_pkg::S_LD_DESC;
                    state_next   = wras_pkg::S_AWAIT;
                end
            end
            wras_pkg::S_LD_DESC: begin
                if (go_left) begin
                    cur_k_next  = kid_l;
                    cur_hi_next = mid;
                end else begin
                    cur_k_next  = kid_r;
                    cur_lo_next = mid_inc;
                end
                state_next = wras_pkg::S_LD_VISIT;
            end
            wras_pkg::S_FIN: begin
                if (out_free) begin
                    stat.res_valid = 1'b1;
                    state_next     = wras_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wras_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wras_pkg::S_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
        alu_ret_reg <= alu_ret_next;
        mem_ret_reg <= mem_ret_next;
        pd_ret_reg  <= pd_ret_next;
        ap_ret_reg  <= ap_ret_next;
        kind_reg    <= kind_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        apv_reg     <= apv_next;
        status_reg  <= status_next;
        cur_k_reg   <= cur_k_next;
        cur_lo_reg  <= cur_lo_next;
        cur_hi_reg  <= cur_hi_next;
        ap_addr_reg <= ap_addr_next;
        sp_reg      <= sp_next;
        node_reg    <= node_next;
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stk_k[push_idx]  <= cur_k_reg;
            stk_lo[push_idx] <= cur_lo_reg;
            stk_hi[push_idx] <= cur_hi_reg;
            stk_ph[push_idx] <= push_ph;
        end
    end

    assign result.status    = status_reg;
    assign result.range_sum = acc_reg;

endmodule

// ===== rtl/core/weighted_range_add_sum_tree.sv =====
// Channel | Direction | Payload (lowest bit first)
// s_      | in        | kind[1:0], range_left[12:2], range_right[23:13], operand_value[53:24]
// m_      | out       | range_sum[29:0], status[30]
// cfg_    | in        | cfg_index 0 element_count, 1 modulus; cfg_wdata
//
// One transaction at a time. Its duration is set by the bit-serial modular reduction in
// the arithmetic unit; a rejected transaction is the shortest, and a wide range add that
// has to push earlier addends down both boundary paths is among the longest.
// After reset a clearing pass zeroes all 4*MAX_ELEMENTS entries of the node memory, with
// s_tready low. One input transaction is buffered while the tree works, and a finished
// result waits in the output register while m_tready is low.
module weighted_range_add_sum_tree #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // kind, range_left, range_right, operand_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // range_sum, status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [29:0] cfg_wdata
);

    localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
    localparam int NW         = $clog2(NODE_DEPTH);
    localparam int PW         = $clog2(MAX_ELEMENTS + 1);

    logic [wras_pkg::CNT_W-1:0] ecount_reg, ecount_next;
    wras_pkg::val_t             modulus_reg, modulus_next;
    logic [31:0]                cnt_wr;

    wras_pkg::item_t            in_item_reg, in_item_next;
    logic                       in_full_reg, in_full_next;
    wras_pkg::result_t          out_reg, out_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic                       out_free;

    wras_pkg::ctrl_stat_t       stat;
    wras_pkg::result_t          result;
    wras_pkg::alu_req_t         alu_req;
    wras_pkg::alu_rsp_t         alu_rsp;
    logic                       mem_we;
    logic [NW-1:0]              mem_waddr;
    wras_pkg::node_t            mem_wdata;
    logic                       mem_re;
    logic [NW-1:0]              mem_raddr;
    wras_pkg::node_t            mem_rdata;

    always_comb begin
        cnt_wr       = 32'(cfg_wdata[10:0]);
        ecount_next  = ecount_reg;
        modulus_next = modulus_reg;
        if (cfg_we) begin
            case (cfg_index)
                wras_pkg::CFG_ECOUNT: begin
                    ecount_next = (cnt_wr > 32'(MAX_ELEMENTS)) ? 11'(MAX_ELEMENTS)
                                                               : cfg_wdata[10:0];
                end
                wras_pkg::CFG_MODULUS: begin
                    modulus_next = (cfg_wdata < wras_pkg::MODULUS_MIN) ? wras_pkg::MODULUS_MIN
                                                                       : cfg_wdata;
                end
                default: begin
                    ecount_next = ecount_reg;
                end
            endcase
        end
    end

    assign s_tready = !in_full_reg && !stat.clearing;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        in_item_next  = in_item_reg;
        in_full_next  = in_full_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (stat.take) begin
            in_full_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_full_next                = 1'b1;
            in_item_next.kind           = s_tdata[1:0];
            in_item_next.range_left     = s_tdata[12:2];
            in_item_next.range_right    = s_tdata[23:13];
            in_item_next.operand_value  = s_tdata[53:24];
        end
        if (stat.res_valid) begin
            out_next      = result;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecount_reg   <= wras_pkg::ECOUNT_RESET;
            modulus_reg  <= wras_pkg::MODULUS_RESET;
            in_full_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            ecount_reg   <= ecount_next;
            modulus_reg  <= modulus_next;
            in_full_reg  <= in_full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        in_item_reg <= in_item_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

    wras_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NW           (NW),
        .PW           (PW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_full_reg),
        .in_item   (in_item_reg),
        .out_free  (out_free),
        .ecount    (ecount_reg),
        .stat      (stat),
        .result    (result),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    wras_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .modulus (modulus_reg),
        .rsp     (alu_rsp)
    );

    wras_node_mem #(
        .ADDR_W (NW),
        .DEPTH  (NODE_DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // rejected transactions never carry a sum
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |-> m_tdata[29:0] == 30'd0)
        else $error("rejected result carries a nonzero sum");

    a_take_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.take |=> !in_full_reg)
        else $error("input buffer still full after the controller took it");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_valid |=> m_tvalid && (m_tdata[30:0] == $past(result)))
        else $error("finished result did not reach the output register");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int TREE_SPAN  = 1024;
    localparam int NODE_DEPTH = 4 * TREE_SPAN;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // kind, range_left, range_right, operand_value
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // range_sum, status
    logic        cfg_we;
    logic        cfg_index;
    logic [29:0] cfg_wdata;

    weighted_range_add_sum_tree #(.MAX_ELEMENTS(TREE_SPAN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // shadow tree
    wras_pkg::val_t        tree_sum [NODE_DEPTH];
    wras_pkg::val_t        tree_wgt [NODE_DEPTH];
    wras_pkg::val_t        tree_lazy[NODE_DEPTH];
    int unsigned           pos_limit;
    wras_pkg::val_t        cur_mod;

    wras_pkg::item_t       pending_items[$];
    wras_pkg::result_t     expected_results[$];
    int                    mismatches;
    int                    results_seen;

    function automatic wras_pkg::val_t mod_add(wras_pkg::val_t a, wras_pkg::val_t b);
        logic [63:0] s;
        s = (64'(a) % cur_mod) + (64'(b) % cur_mod);
        return wras_pkg::val_t'(s % cur_mod);
    endfunction

    function automatic wras_pkg::val_t mod_mul(wras_pkg::val_t a, wras_pkg::val_t b);
        logic [63:0] p;
        p = (64'(a) % cur_mod) * (64'(b) % cur_mod);
        return wras_pkg::val_t'(p % cur_mod);
    endfunction

    function automatic void tag_node(int k, wras_pkg::val_t v);
        tree_lazy[k] = mod_add(tree_lazy[k], v);
        tree_sum[k]  = mod_add(tree_sum[k], mod_mul(tree_wgt[k], v));
    endfunction

    function automatic void push_lazy(int k);
        wras_pkg::val_t p;
        p = wras_pkg::val_t'(64'(tree_lazy[k]) % cur_mod);
        if (p != 0) begin
            tag_node(2 * k, p);
            tag_node(2 * k + 1, p);
        end
        tree_lazy[k] = '0;
    endfunction

    function automatic void add_weight(int k, int lo, int hi, int pos, wras_pkg::val_t w);
        int mid;
        tree_wgt[k] = mod_add(tree_wgt[k], w);
        if (lo == hi) return;
        push_lazy(k);
        mid = (lo + hi) >> 1;
        if (pos <= mid) add_weight(2 * k, lo, mid, pos, w);
        else add_weight(2 * k + 1, mid + 1, hi, pos, w);
    endfunction

    function automatic void add_range(int k, int lo, int hi, int l, int r, wras_pkg::val_t v);
        int mid;
        if (l <= lo && hi <= r) begin
            tag_node(k, v);
            return;
        end
        push_lazy(k);
        mid = (lo + hi) >> 1;
        if (l <= mid) add_range(2 * k, lo, mid, l, r, v);
        if (r > mid) add_range(2 * k + 1, mid + 1, hi, l, r, v);
        tree_sum[k] = mod_add(tree_sum[2 * k], tree_sum[2 * k + 1]);
    endfunction

    function automatic wras_pkg::val_t sum_range(int k, int lo, int hi, int l, int r);
        int             mid;
        wras_pkg::val_t acc;
        acc = '0;
        if (l <= lo && hi <= r) return wras_pkg::val_t'(64'(tree_sum[k]) % cur_mod);
        push_lazy(k);
        mid = (lo + hi) >> 1;
        if (l <= mid) acc = mod_add(acc, sum_range(2 * k, lo, mid, l, r));
        if (r > mid) acc = mod_add(acc, sum_range(2 * k + 1, mid + 1, hi, l, r));
        return acc;
    endfunction

    function automatic wras_pkg::result_t tree_step(wras_pkg::item_t it);
        wras_pkg::result_t res;
        int                l, r;
        wras_pkg::val_t    v;
        res = '0;
        l = it.range_left;
        r = it.range_right;
        v = wras_pkg::val_t'(64'(it.operand_value) % cur_mod);
        if (it.kind == wras_pkg::KIND_LOAD) begin
            if (l < 1 || l > pos_limit) res.status = 1'b1;
            else add_weight(1, 1, TREE_SPAN, l, v);
        end else if (it.kind == wras_pkg::KIND_ADD || it.kind == wras_pkg::KIND_QUERY) begin
            if (l < 1 || r > pos_limit || l > r) res.status = 1'b1;
            else if (it.kind == wras_pkg::KIND_ADD) add_range(1, 1, TREE_SPAN, l, r, v);
            else res.range_sum = sum_range(1, 1, TREE_SPAN, l, r);
        end else begin
            res.status = 1'b1;
        end
        return res;
    endfunction

    // driver: bursts of random length with random gaps
    wras_pkg::item_t cur_item;
    int              burst_left;
    int              gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(tree_step(cur_item));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= 56'({cur_item.operand_value, cur_item.range_right,
                                     cur_item.range_left, cur_item.kind});
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern and one long hold-off
    int  hold_cnt;
    bit  long_hold_done;
    int  stall_mode;

    always @(posedge aclk) begin
        wras_pkg::result_t exp_res;
        if (!aresetn) begin
            m_tready       <= 1'b0;
            hold_cnt       = 0;
            long_hold_done = 0;
            stall_mode     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h", m_tdata);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[29:0] !== exp_res.range_sum ||
                        m_tdata[30] !== exp_res.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: sum exp %0d got %0d, status exp %0d got %0d",
                                     results_seen, exp_res.range_sum, m_tdata[29:0],
                                     exp_res.status, m_tdata[30]);
                    end
                end
                if (results_seen == 500 && !long_hold_done) begin
                    long_hold_done = 1;
                    hold_cnt = 30000;
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (stall_mode == 0) begin
                m_tready <= 1'b1;
            end else if (stall_mode == 1) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_tready <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [29:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == wras_pkg::CFG_ECOUNT)
            pos_limit = (value[10:0] > TREE_SPAN) ? TREE_SPAN : value[10:0];
        else
            cur_mod = (value < 2) ? wras_pkg::MODULUS_MIN : value;
    endtask

    function automatic wras_pkg::item_t mk(logic [1:0] k, int l, int r, wras_pkg::val_t v);
        wras_pkg::item_t it;
        it.kind = k;
        it.range_left = wras_pkg::POS_W'(l);
        it.range_right = wras_pkg::POS_W'(r);
        it.operand_value = v;
        return it;
    endfunction

    function automatic wras_pkg::val_t rand_operand();
        case ($urandom_range(0, 3))
            0: return wras_pkg::val_t'($urandom_range(0, 20));
            1: return '1;
            default: return wras_pkg::val_t'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        int   sel, l, r;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (pos_limit == 0 || sel >= 90) begin
                pending_items.push_back(mk(2'($urandom), $urandom_range(0, 2047),
                                           $urandom_range(0, 2047),
                                           wras_pkg::val_t'($urandom)));
            end else begin
                l = $urandom_range(1, pos_limit);
                if ($urandom_range(0, 3) == 0) r = $urandom_range(l, pos_limit);
                else r = (l + $urandom_range(0, 40) > pos_limit) ? pos_limit
                                                                 : l + $urandom_range(0, 40);
                if (sel < 12)
                    pending_items.push_back(mk(wras_pkg::KIND_LOAD, l, 0, rand_operand()));
                else if (sel < 45)
                    pending_items.push_back(mk(wras_pkg::KIND_ADD, l, r, rand_operand()));
                else
                    pending_items.push_back(mk(wras_pkg::KIND_QUERY, l, r,
                                               wras_pkg::val_t'($urandom)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NODE_DEPTH; i++) begin
            tree_sum[i] = '0;
            tree_wgt[i] = '0;
            tree_lazy[i] = '0;
        end
        pos_limit    = wras_pkg::ECOUNT_RESET;
        cur_mod      = wras_pkg::MODULUS_RESET;
        mismatches   = 0;
        results_seen = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: only position 1 is valid
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 1, 0, 5));
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 2, 0, 5));
        pending_items.push_back(mk(wras_pkg::KIND_ADD, 1, 1, 7));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1, 1, 0));
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 1024);
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 1, 0, '1));
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 1024, 0, 30'd123456789));
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 0, 0, 9));            // bad position
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 1025, 0, 9));
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 2047, 2047, 9));
        pending_items.push_back(mk(2'd3, 1, 10, 9));                          // unknown kind
        pending_items.push_back(mk(wras_pkg::KIND_ADD, 1, 1024, '1));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1, 1024, 0));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1, 1, 0));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1024, 1024, 0));
        pending_items.push_back(mk(wras_pkg::KIND_ADD, 10, 9, 3));            // empty interval
        pending_items.push_back(mk(wras_pkg::KIND_ADD, 0, 5, 3));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 5, 1025, 0));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 2047, 2047, 0));
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 1, 0, 30'd77));       // load after add
        pending_items.push_back(mk(wras_pkg::KIND_LOAD, 512, 0, 30'd1000));
        pending_items.push_back(mk(wras_pkg::KIND_ADD, 300, 700, 30'd999));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1, 512, 0));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 2, 1023, 0));
        pending_items.push_back(mk(wras_pkg::KIND_QUERY, 1, 1024, 0));
        wait_drained();

        write_reg(wras_pkg::CFG_MODULUS, 30'h3FFFFFFF);
        queue_random(300);
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 8);
        write_reg(wras_pkg::CFG_MODULUS, 0);                       // raised to the minimum
        queue_random(100);
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 2047);                     // saturates
        write_reg(wras_pkg::CFG_MODULUS, 1000003);
        queue_random(250);
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 0);                        // nothing valid
        write_reg(wras_pkg::CFG_MODULUS, 1);
        queue_random(30);
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 64);
        write_reg(wras_pkg::CFG_MODULUS, 65521);
        queue_random(150);
        wait_drained();
        queue_random(150);
        wait_drained();

        write_reg(wras_pkg::CFG_ECOUNT, 1024);
        write_reg(wras_pkg::CFG_MODULUS, 999999937);               // tree keeps old values
        queue_random(300);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(64'd3_000_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== weighted_range_add_sum_tree.f =====
rtl/core/wras_pkg.sv
rtl/core/wras_node_mem.sv
rtl/core/wras_alu.sv
rtl/core/wras_ctrl.sv
rtl/core/weighted_range_add_sum_tree.sv
tb/testbench.sv
